### src/plcm_pkg.sv
// Shared types and constants for the piecewise linear color map.
package plcm_pkg;

    localparam int MAX_POINTS_DEF  = 5;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int POS_BITS   = 17;   // Q1.16 position, 65536 = 1.0
    localparam int FRAC_BITS  = 16;
    localparam int CHAN_BITS  = 8;
    localparam int COLOR_BITS = 3 * CHAN_BITS;
    localparam int POINT_BITS = POS_BITS + COLOR_BITS;
    localparam int NUM_BITS   = POS_BITS + CHAN_BITS + 1;
    localparam int CNT_BITS   = 3;
    localparam int ADDR_BITS  = 6;
    localparam int DATA_BITS  = 64;
    localparam int IDX_BITS   = 3;

    localparam logic [IDX_BITS-1:0] REG_RANGE_MIN   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_RANGE_MAX   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_POINT_COUNT = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_POINT_BASE  = 3'd3;

    localparam logic [CNT_BITS-1:0] POINT_COUNT_RESET = 3'd5;
    localparam int RANGE_MAX_RESET = 32767;

    localparam logic [POINT_BITS-1:0] POINT_RESET [5] = '{
        41'd11141120, 41'd274894669824, 41'd549771801587,
        41'd971152836223, 41'd1099511627776
    };

    typedef enum logic [1:0] {
        SEL_FIRST = 2'd0,
        SEL_LAST  = 2'd1,
        SEL_POS   = 2'd2
    } sel_kind_t;

    typedef struct packed {
        sel_kind_t           kind;
        logic [POS_BITS-1:0] pos;
    } cmap_item_t;

endpackage

### src/plcm_front.sv
// Front end: range classification and pipelined position divider.
module plcm_front #(
    parameter int SAMPLE_BITS = plcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] range_min,
    input  logic [SAMPLE_BITS-1:0] range_max,
    output logic                   item_valid,
    output plcm_pkg::cmap_item_t   item
);
    import plcm_pkg::*;

    localparam int RW = SAMPLE_BITS + POS_BITS;

    logic                   lo, hi;
    logic [SAMPLE_BITS-1:0] diff, num;
    sel_kind_t              kind0;
    logic [RW-1:0]          rem0;
    logic [SAMPLE_BITS-1:0] dv0;

    logic                   v_reg    [POS_BITS+1];
    sel_kind_t              kind_reg [POS_BITS+1];
    logic [RW-1:0]          rem_reg  [POS_BITS+1];
    logic [SAMPLE_BITS-1:0] dv_reg   [POS_BITS+1];
    logic [POS_BITS-1:0]    q_reg    [POS_BITS+1];

    always_comb
    begin
        lo   = $signed(sample) < $signed(range_min);
        hi   = $signed(sample) > $signed(range_max);
        diff = range_max - range_min;
        num  = sample - range_min;
        if (lo)
            kind0 = SEL_FIRST;
        else if (hi)
            kind0 = SEL_LAST;
        else
            kind0 = SEL_POS;
        // out of range or degenerate range: divide 0 by 1 so pos = 0
        if (lo || hi || diff == '0)
        begin
            rem0 = '0;
            dv0  = SAMPLE_BITS'(1);
        end
        else
        begin
            rem0 = RW'({num, {FRAC_BITS{1'b0}}}) + RW'(diff >> 1);
            dv0  = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        kind_reg[0] <= kind0;
        rem_reg[0]  <= rem0;
        dv_reg[0]   <= dv0;
        q_reg[0]    <= '0;
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < POS_BITS; j++)
    begin : g_div
        localparam int K = POS_BITS - 1 - j;
        logic [RW-1:0] trial;
        logic          ge;

        always_comb
        begin
            trial = RW'(dv_reg[j]) << K;
            ge    = rem_reg[j] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            kind_reg[j+1] <= kind_reg[j];
            dv_reg[j+1]   <= dv_reg[j];
            rem_reg[j+1]  <= ge ? rem_reg[j] - trial : rem_reg[j];
            q_reg[j+1]    <= q_reg[j] | (ge ? POS_BITS'(1) << K : '0);
        end
    end

    assign item_valid = v_reg[POS_BITS];
    assign item.kind  = kind_reg[POS_BITS];
    assign item.pos   = q_reg[POS_BITS];

endmodule

### src/plcm_fifo.sv
// Two-entry queue between front and back end.
module plcm_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  plcm_pkg::cmap_item_t push_item,
    output logic                 full,
    output logic                 head_valid,
    output plcm_pkg::cmap_item_t head_item
);
    import plcm_pkg::*;

    cmap_item_t mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    always_comb
    begin
        // back end never stalls: pop whenever an entry waits
        pop        = cnt_reg != 2'd0;
        head_valid = pop;
        head_item  = mem_reg[rd_reg];
        full       = cnt_reg == 2'd2;
        wr_next    = push ? ~wr_reg : wr_reg;
        rd_next    = pop ? ~rd_reg : rd_reg;
        cnt_next   = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

### src/plcm_back.sv
// Back end: segment search, channel blend and pipelined channel dividers.
module plcm_back #(
    parameter int MAX_POINTS = plcm_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  plcm_pkg::cmap_item_t                item,
    input  logic [plcm_pkg::CNT_BITS-1:0]       point_count,
    input  logic [plcm_pkg::POINT_BITS-1:0]     points [MAX_POINTS],
    output logic                                done,
    output logic [plcm_pkg::CHAN_BITS-1:0]      red,
    output logic [plcm_pkg::CHAN_BITS-1:0]      green,
    output logic [plcm_pkg::CHAN_BITS-1:0]      blue
);
    import plcm_pkg::*;

    localparam int NW = NUM_BITS;

    logic [CNT_BITS-1:0]   n_eff;
    logic [POINT_BITS-1:0] last_pt;
    logic                  found, dir_c;
    logic [COLOR_BITS-1:0] col_c, c1_c, c2_c;
    logic signed [POS_BITS:0] t_s, d_s;
    logic [POS_BITS-1:0]   t_c, d_c;

    // segment select stage
    logic                  s1_v_reg, s1_dir_reg;
    logic [COLOR_BITS-1:0] s1_col_reg, s1_c1_reg, s1_c2_reg;
    logic [POS_BITS-1:0]   s1_t_reg, s1_d_reg;

    // blend stage and divider stages
    logic                  v_reg   [CHAN_BITS+1];
    logic                  dir_reg [CHAN_BITS+1];
    logic [COLOR_BITS-1:0] col_reg [CHAN_BITS+1];
    logic [POS_BITS-1:0]   d_reg   [CHAN_BITS+1];
    logic [NW-1:0]         num_reg [CHAN_BITS+1][3];
    logic [CHAN_BITS-1:0]  q_reg   [CHAN_BITS+1][3];

    logic                  done_reg;
    logic [CHAN_BITS-1:0]  red_reg, green_reg, blue_reg;

    always_comb
    begin
        if (point_count == '0)
            n_eff = CNT_BITS'(1);
        else if (point_count > CNT_BITS'(MAX_POINTS))
            n_eff = CNT_BITS'(MAX_POINTS);
        else
            n_eff = point_count;

        last_pt = points[0];
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (CNT_BITS'(i) == n_eff - CNT_BITS'(1))
                last_pt = points[i];
        end

        found = 1'b0;
        dir_c = 1'b1;
        col_c = last_pt[COLOR_BITS-1:0];
        c1_c  = '0;
        c2_c  = '0;
        t_s   = '0;
        d_s   = '0;
        t_c   = '0;
        d_c   = '0;
        unique case (item.kind)
            SEL_FIRST: col_c = points[0][COLOR_BITS-1:0];
            SEL_LAST:  col_c = last_pt[COLOR_BITS-1:0];
            SEL_POS:
            begin
                for (int i = 0; i < MAX_POINTS - 1; i++)
                begin
                    if (!found && CNT_BITS'(i + 1) < n_eff
                        && item.pos < points[i+1][POINT_BITS-1:COLOR_BITS])
                    begin
                        found = 1'b1;
                        t_s = $signed({1'b0, item.pos})
                            - $signed({1'b0, points[i][POINT_BITS-1:COLOR_BITS]});
                        d_s = $signed({1'b0, points[i+1][POINT_BITS-1:COLOR_BITS]})
                            - $signed({1'b0, points[i][POINT_BITS-1:COLOR_BITS]});
                        c1_c = points[i][COLOR_BITS-1:0];
                        c2_c = points[i+1][COLOR_BITS-1:0];
                    end
                end
                if (found)
                begin
                    // below the lower point or empty segment: no extrapolation
                    if (t_s < 0 || d_s <= 0)
                        col_c = c1_c;
                    else
                    begin
                        dir_c = 1'b0;
                        t_c   = t_s[POS_BITS-1:0];
                        d_c   = d_s[POS_BITS-1:0];
                    end
                end
            end
            default: col_c = last_pt[COLOR_BITS-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else
        begin
            s1_v_reg <= item_valid;
            v_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dir_reg <= dir_c;
        s1_col_reg <= col_c;
        s1_c1_reg  <= c1_c;
        s1_c2_reg  <= c2_c;
        s1_t_reg   <= t_c;
        s1_d_reg   <= d_c;
    end

    // c1*(d-t) + c2*t + d/2, the rounded blend numerator
    always_ff @(posedge clk)
    begin
        dir_reg[0] <= s1_dir_reg;
        col_reg[0] <= s1_col_reg;
        d_reg[0]   <= s1_d_reg;
        for (int c = 0; c < 3; c++)
        begin
            num_reg[0][c] <=
                NW'(s1_c1_reg[COLOR_BITS-1-CHAN_BITS*c -: CHAN_BITS])
                    * NW'(s1_d_reg - s1_t_reg)
                + NW'(s1_c2_reg[COLOR_BITS-1-CHAN_BITS*c -: CHAN_BITS])
                    * NW'(s1_t_reg)
                + NW'(s1_d_reg >> 1);
            q_reg[0][c] <= '0;
        end
    end

    for (genvar j = 0; j < CHAN_BITS; j++)
    begin : g_div
        localparam int K = CHAN_BITS - 1 - j;
        logic [NW-1:0] trial;

        assign trial = NW'(d_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dir_reg[j+1] <= dir_reg[j];
            col_reg[j+1] <= col_reg[j];
            d_reg[j+1]   <= d_reg[j];
            for (int c = 0; c < 3; c++)
            begin
                if (num_reg[j][c] >= trial)
                begin
                    num_reg[j+1][c] <= num_reg[j][c] - trial;
                    q_reg[j+1][c]   <= q_reg[j][c] | (CHAN_BITS'(1) << K);
                end
                else
                begin
                    num_reg[j+1][c] <= num_reg[j][c];
                    q_reg[j+1][c]   <= q_reg[j][c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_reg[CHAN_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (dir_reg[CHAN_BITS])
        begin
            red_reg   <= col_reg[CHAN_BITS][COLOR_BITS-1 -: CHAN_BITS];
            green_reg <= col_reg[CHAN_BITS][COLOR_BITS-1-CHAN_BITS -: CHAN_BITS];
            blue_reg  <= col_reg[CHAN_BITS][CHAN_BITS-1:0];
        end
        else
        begin
            red_reg   <= q_reg[CHAN_BITS][0];
            green_reg <= q_reg[CHAN_BITS][1];
            blue_reg  <= q_reg[CHAN_BITS][2];
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

### src/piecewise_linear_color_map_unit.sv
// Top level of the piecewise linear color map: registers, front, queue, back.
// Output: done is high for one cycle for each accepted start transfer.
// Throughput: one sample per cycle; the 17-stage position divider and the
// 8-stage channel dividers are fully pipelined. busy stays low in operation.
// Reset: asynchronous active low rst_n clears all control state and loads
// the register defaults; no clearing pass is needed.
module piecewise_linear_color_map_unit #(
    parameter int MAX_POINTS  = plcm_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = plcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              done,
    output logic [plcm_pkg::CHAN_BITS-1:0]    red,
    output logic [plcm_pkg::CHAN_BITS-1:0]    green,
    output logic [plcm_pkg::CHAN_BITS-1:0]    blue,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [plcm_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [plcm_pkg::DATA_BITS-1:0]    pwdata,
    output logic [plcm_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import plcm_pkg::*;

    logic [SAMPLE_BITS-1:0] range_min_reg, range_max_reg;
    logic [CNT_BITS-1:0]    point_count_reg;
    logic [POINT_BITS-1:0]  points_reg [MAX_POINTS];

    logic                   wr_en;
    logic [IDX_BITS-1:0]    idx;
    logic                   accept;
    logic                   f_valid, q_full, q_valid;
    cmap_item_t             f_item, q_item;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= '0;
            range_max_reg   <= SAMPLE_BITS'(RANGE_MAX_RESET);
            point_count_reg <= POINT_COUNT_RESET;
            for (int i = 0; i < MAX_POINTS; i++)
                points_reg[i] <= POINT_RESET[i];
        end
        else if (wr_en)
        begin
            if (idx == REG_RANGE_MIN)
                range_min_reg <= pwdata[SAMPLE_BITS-1:0];
            if (idx == REG_RANGE_MAX)
                range_max_reg <= pwdata[SAMPLE_BITS-1:0];
            if (idx == REG_POINT_COUNT)
                point_count_reg <= pwdata[CNT_BITS-1:0];
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (idx == REG_POINT_BASE + IDX_BITS'(i))
                    points_reg[i] <= pwdata[POINT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx == REG_RANGE_MIN)
            prdata = DATA_BITS'($signed(range_min_reg));
        else if (idx == REG_RANGE_MAX)
            prdata = DATA_BITS'($signed(range_max_reg));
        else if (idx == REG_POINT_COUNT)
            prdata = DATA_BITS'(point_count_reg);
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (idx == REG_POINT_BASE + IDX_BITS'(i))
                prdata = DATA_BITS'(points_reg[i]);
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    plcm_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .range_min (range_min_reg),
        .range_max (range_max_reg),
        .item_valid(f_valid),
        .item      (f_item)
    );

    plcm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .full      (q_full),
        .head_valid(q_valid),
        .head_item (q_item)
    );

    plcm_back #(
        .MAX_POINTS(MAX_POINTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .point_count(point_count_reg),
        .points     (points_reg),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
